>>> src/swvf_pkg.sv
// Package for the sliding window vote filter.
// Holds the window and class constants, register map and shared types.
// No dependencies.
`default_nettype none

package swvf_pkg;

   // Window length and number of classes.
   localparam int WINDOW_LEN  = 15;
   localparam int NUM_CLASSES = 7;

   // Field and state widths.
   localparam int LABEL_W  = 3;
   localparam int THRESH_W = 4;
   localparam int COUNT_W  = $clog2(WINDOW_LEN + 1);
   localparam int CLASS_W  = $clog2(NUM_CLASSES);
   localparam int CMP_W    = (COUNT_W > THRESH_W) ? COUNT_W : THRESH_W;

   // Saturation value of a vote count.
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(WINDOW_LEN);

   // Configuration register map: one 32-bit register per word.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_VOTE_THRESHOLD = CSR_IDX_W'(0);
   localparam logic [THRESH_W-1:0]  THRESH_RESET           = THRESH_W'(7);

   // Winner of the vote after the current update.
   typedef struct packed {
      logic [CLASS_W-1:0] best_class;
      logic [COUNT_W-1:0] best_count;
   } vote_result_type;

endpackage

`default_nettype wire

>>> src/swvf_window.sv
// Label window of the vote filter: a shift line of the last WINDOW_LEN labels.
// The oldest label sits at the far end of the line. Depends on swvf_pkg.
`default_nettype none

module swvf_window (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        shift_en,
   input  wire logic [swvf_pkg::LABEL_W-1:0] new_label,
   output logic      [swvf_pkg::LABEL_W-1:0] oldest_label
);
   import swvf_pkg::*;

   logic [LABEL_W-1:0] taps_ff [WINDOW_LEN];

   // The window starts full of class 0 and moves one place per accepted label in range.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            taps_ff[i] <= '0;
         end
      end else if (shift_en) begin
         taps_ff[0] <= new_label;
         for (int i = 1; i < WINDOW_LEN; i++) begin
            taps_ff[i] <= taps_ff[i-1];
         end
      end
   end

   assign oldest_label = taps_ff[WINDOW_LEN-1];

endmodule

`default_nettype wire

>>> src/swvf_votes.sv
// Vote counters of the filter with the update and the winner search.
// Counts the leaving label down and the new label up, then finds the winner.
// Depends on swvf_pkg.
`default_nettype none

module swvf_votes (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         update_en,
   input  wire logic [swvf_pkg::LABEL_W-1:0] new_label,
   input  wire logic [swvf_pkg::LABEL_W-1:0] oldest_label,
   output swvf_pkg::vote_result_type         vote
);
   import swvf_pkg::*;

   logic [COUNT_W-1:0] counts_ff [NUM_CLASSES];
   logic [COUNT_W-1:0] counts_in [NUM_CLASSES];

   // Take one vote from the oldest class (never below zero), then add one
   // to the new class (saturating at the window length).
   always_comb begin
      logic [COUNT_W-1:0] dec;
      for (int i = 0; i < NUM_CLASSES; i++) begin
         dec = counts_ff[i];
         if (32'(oldest_label) == 32'(i) && dec != '0) begin
            dec = dec - COUNT_W'(1);
         end
         if (32'(new_label) == 32'(i) && dec != COUNT_MAX) begin
            dec = dec + COUNT_W'(1);
         end
         counts_in[i] = dec;
      end
   end

   // Largest updated count; the lowest class wins a tie.
   always_comb begin
      logic [CLASS_W-1:0] idx;
      logic [COUNT_W-1:0] cnt;
      idx = '0;
      cnt = counts_in[0];
      for (int i = 1; i < NUM_CLASSES; i++) begin
         if (counts_in[i] > cnt) begin
            cnt = counts_in[i];
            idx = CLASS_W'(i);
         end
      end
      vote.best_class = idx;
      vote.best_count = cnt;
   end

   // Counters start at zero and change only for a label in range.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (update_en) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            counts_ff[i] <= counts_in[i];
         end
      end
   end

endmodule

`default_nettype wire

>>> src/sliding_window_vote_filter.sv
// Sliding window vote filter, top level.
// Takes one class label per word and reports a class when it becomes stable.
//
// Input channel (req_): one class label per word. A label of NUM_CLASSES or
// more is taken and dropped without touching the state.
// Result channel (rsp_): the newly stable class, sent only when the winning
// vote count exceeds vote_threshold and the class differs from the one last
// reported. A label gives zero or one result word.
// Configuration (csr_): vote_threshold at byte address 0, written and read
// over the APB-style port; pready is always high. Write it only while idle.
// A label waits in the input register; its result, if any, is registered in
// the result register and offered on rsp_ from there.
// Throughput: one label per cycle while the result register is free or drains.
// The window update, the counter update and the winner search are all done
// between the input register and the result register.
// Reset: the window holds class 0, all counts are zero, the last reported
// class is 0 and vote_threshold is 7.
// Stall: while a result waits for rsp_ready, the input register still holds
// one more label; labels that give no result keep flowing behind it only
// when the result register frees up.
// Depends on swvf_pkg, swvf_window and swvf_votes.
`default_nettype none

module sliding_window_vote_filter (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Input channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [swvf_pkg::LABEL_W-1:0]    req_class_label,
   // Result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [swvf_pkg::LABEL_W-1:0]    rsp_reported_class,
   // Configuration port
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [swvf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [swvf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [swvf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import swvf_pkg::*;

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [LABEL_W-1:0]     in_label_ff;
   logic                   in_ok_ff;
   logic                   req_take;
   logic                   label_ok;
   logic                   fire;
   logic                   update_en;
   logic                   emit;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [LABEL_W-1:0]     rsp_class_ff;
   logic [CLASS_W-1:0]     last_reported_ff;
   logic [THRESH_W-1:0]    thresh_ff;
   logic [CSR_IDX_W-1:0]   csr_idx;
   logic [LABEL_W-1:0]     oldest_label;
   vote_result_type        vote;

   // Configuration register write and read.
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_idx == CSR_IDX_VOTE_THRESHOLD) begin
         thresh_ff <= csr_pwdata[THRESH_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_idx == CSR_IDX_VOTE_THRESHOLD) begin
         csr_prdata = CSR_DATA_W'(thresh_ff);
      end
   end

   // The processing step moves on when the result register is free or drains.
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign req_take  = req_valid && req_ready;
   assign label_ok  = 32'(req_class_label) < 32'(NUM_CLASSES);
   assign update_en = fire && in_ok_ff;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_label_ff <= req_class_label;
         in_ok_ff    <= label_ok;
      end
   end

   // Window and vote counters.
   swvf_window u_window (
      .clock        (clock),
      .reset        (reset),
      .shift_en     (update_en),
      .new_label    (in_label_ff),
      .oldest_label (oldest_label)
   );

   swvf_votes u_votes (
      .clock        (clock),
      .reset        (reset),
      .update_en    (update_en),
      .new_label    (in_label_ff),
      .oldest_label (oldest_label),
      .vote         (vote)
   );

   // Report a class that clears the threshold and differs from the last one.
   assign emit = update_en
                 && (CMP_W'(vote.best_count) > CMP_W'(thresh_ff))
                 && (vote.best_class != last_reported_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         last_reported_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (emit) begin
            last_reported_ff <= vote.best_class;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_class_ff <= LABEL_W'(vote.best_class);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reported_class = rsp_class_ff;

endmodule

`default_nettype wire

>>> bench/swvf_vote_checker.sv
// Scoreboard for the sliding window vote filter: watches the label, result and
// register channels, predicts every result word and compares it on arrival.
// Depends on swvf_pkg.
module swvf_vote_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_ready,
   input  wire logic [swvf_pkg::LABEL_W-1:0]    req_class_label,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic [swvf_pkg::LABEL_W-1:0]    rsp_reported_class,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [swvf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [swvf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic [swvf_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  wire logic                            csr_pready,
   output int                                   mismatch_count,
   output int                                   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import swvf_pkg::*;

   localparam int MAX_REPORTS = 10;

   // Shadow copy of the filter state.
   logic [LABEL_W-1:0]  window_labels [WINDOW_LEN];
   logic [COUNT_W-1:0]  class_votes [NUM_CLASSES];
   logic [LABEL_W-1:0]  last_class;
   logic [THRESH_W-1:0] vote_threshold;
   int unsigned         oldest_pos;

   // Classes that are still due on the result channel, oldest first.
   logic [LABEL_W-1:0]  expected_classes [$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   task automatic log_mismatch(input string detail);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t ns: mismatch, %s", $time, detail);
      end
   endtask

   task automatic clear_state();
      foreach (window_labels[i]) window_labels[i] = '0;
      foreach (class_votes[i]) class_votes[i] = '0;
      last_class     = '0;
      vote_threshold = THRESH_RESET;
      oldest_pos     = 0;
      expected_classes.delete();
   endtask

   // One label through the vote: retire the oldest label, count the new one,
   // then report the winner if it is strong enough and has changed.
   task automatic cast_vote(input logic [LABEL_W-1:0] label, output bit emits,
                            output logic [LABEL_W-1:0] winner);
      logic [LABEL_W-1:0] oldest;
      int unsigned        best;
      emits  = 1'b0;
      winner = '0;
      // Labels beyond the last class leave the state alone.
      if (label >= NUM_CLASSES) return;
      oldest = window_labels[oldest_pos];
      if (oldest < NUM_CLASSES && class_votes[oldest] != '0) begin
         class_votes[oldest] = class_votes[oldest] - 1'b1;
      end
      window_labels[oldest_pos] = label;
      oldest_pos = (oldest_pos + 1 == WINDOW_LEN) ? 0 : oldest_pos + 1;
      if (class_votes[label] < COUNT_MAX) begin
         class_votes[label] = class_votes[label] + 1'b1;
      end
      // The lowest class index wins a tie.
      best = 0;
      for (int i = 1; i < NUM_CLASSES; i++) begin
         if (class_votes[i] > class_votes[best]) best = i;
      end
      if (class_votes[best] > vote_threshold && LABEL_W'(best) != last_class) begin
         last_class = LABEL_W'(best);
         winner     = LABEL_W'(best);
         emits      = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      bit                 emits;
      logic [LABEL_W-1:0] winner;
      logic [LABEL_W-1:0] want;
      if (reset) begin
         clear_state();
      end else begin
         // Register accesses: writes update the shadow, reads are checked.
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_VOTE_THRESHOLD) begin
            if (csr_pwrite) begin
               vote_threshold = csr_pwdata[THRESH_W-1:0];
            end else if (csr_prdata !== CSR_DATA_W'(vote_threshold)) begin
               log_mismatch($sformatf("vote_threshold read expected %0d, got %0d",
                                      vote_threshold, csr_prdata));
            end
         end
         // Each result word is held against the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            if (expected_classes.size() == 0) begin
               log_mismatch($sformatf("unexpected result word, reported_class %0d",
                                      rsp_reported_class));
            end else begin
               want = expected_classes[0];
               expected_classes.delete(0);
               if (rsp_reported_class !== want) begin
                  log_mismatch($sformatf("reported_class expected %0d, got %0d",
                                         want, rsp_reported_class));
               end
            end
         end
         // Each accepted label word may add one prediction.
         if (req_valid && req_ready) begin
            cast_vote(req_class_label, emits, winner);
            if (emits) expected_classes = {expected_classes, winner};
         end
      end
      pending_count = expected_classes.size();
   end

endmodule

>>> bench/sliding_window_vote_filter_tb.sv
// Top of the sliding window vote filter bench: clock, reset, label and
// register stimulus, result back pressure and the verdict.
// Depends on swvf_pkg, sliding_window_vote_filter and swvf_vote_checker.
module sliding_window_vote_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import swvf_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SEGMENTS     = 10;
   localparam int SEG_ITEMS    = 95;
   localparam int LONG_STALL   = 250;
   localparam int DRAIN_CYCLES = 8;
   localparam int LABEL_TOP    = (1 << LABEL_W) - 1;
   localparam logic [LABEL_W-1:0]   LABEL_IGNORED    = LABEL_W'(NUM_CLASSES);
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_UNMAPPED = CSR_IDX_W'(1);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [LABEL_W-1:0]    req_class_label = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [LABEL_W-1:0]    rsp_reported_class;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int pending_count;
   int cycle_count = 0;
   int tx_idle_pct = 10;
   int rx_idle_pct = 80;
   bit long_stall_armed = 1'b0;
   bit long_stall_done = 1'b0;

   // Opening labels: every class, an ignored label, then a long run of the
   // top class so that it outvotes the threshold.
   int opening_labels [18] = '{0, 1, 2, 3, 4, 5, 6, NUM_CLASSES,
                               6, 6, 6, 6, 6, 6, 6, 6, 6, 6};
   int segment_thresholds [SEGMENTS] = '{15, 0, 7, 9, 4, 12, 1, 0, 2, 5};

   sliding_window_vote_filter i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_class_label    (req_class_label),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_reported_class (rsp_reported_class),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   swvf_vote_checker u_vote_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_class_label    (req_class_label),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_reported_class (rsp_reported_class),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result side back pressure, with one long hold-off once it is armed.
   initial begin
      forever begin
         @(negedge clock);
         if (long_stall_armed && !long_stall_done) begin
            long_stall_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_STALL) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Offer one label word; called and left at a falling edge.
   task automatic send_label(input logic [LABEL_W-1:0] label);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_class_label <= label;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // One register access with setup and access cycles.
   task automatic csr_access(input bit write, input logic [CSR_IDX_W-1:0] idx,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Write the threshold with junk in the upper bits, then read it back.
   task automatic set_threshold(input logic [THRESH_W-1:0] value);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom();
      data[THRESH_W-1:0] = value;
      csr_access(1'b1, CSR_IDX_VOTE_THRESHOLD, data);
      csr_access(1'b0, CSR_IDX_VOTE_THRESHOLD, '0);
   endtask

   // Stop offering labels and let every predicted result come out, plus the
   // labels still in the pipeline that give no result.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int                 sent;
      int                 run_len;
      bit                 noisy;
      logic [LABEL_W-1:0] run_class;
      logic [LABEL_W-1:0] label;

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset threshold; the read checks the reset value.
      csr_access(1'b0, CSR_IDX_VOTE_THRESHOLD, '0);
      foreach (opening_labels[i]) send_label(LABEL_W'(opening_labels[i]));
      drain();
      // A write to an unmapped register must leave the threshold alone.
      csr_access(1'b1, CSR_IDX_UNMAPPED, $urandom());
      csr_access(1'b0, CSR_IDX_VOTE_THRESHOLD, '0);
      set_threshold('0);
      send_label(LABEL_W'(1));
      send_label(LABEL_W'(2));
      send_label(LABEL_IGNORED);
      send_label(LABEL_W'(1));
      send_label(LABEL_W'(0));

      // Random part: runs of one class with a little noise, one threshold per
      // segment, idling moved from the receiver to the sender and then off.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain();
         if (seg < 4) begin
            tx_idle_pct = 10;
            rx_idle_pct = 80;
         end else if (seg < 7) begin
            tx_idle_pct = 80;
            rx_idle_pct = 10;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         set_threshold(THRESH_W'(segment_thresholds[seg]));
         if (seg == SEGMENTS - 1) begin
            set_threshold(THRESH_W'($urandom_range((1 << THRESH_W) - 1)));
         end
         // With a zero threshold results come often, so a long hold-off
         // here backs the filter up into its input.
         if (seg == 7) long_stall_armed = 1'b1;
         sent = 0;
         while (sent < SEG_ITEMS) begin
            run_class = LABEL_W'($urandom_range(NUM_CLASSES - 1));
            run_len   = $urandom_range(24, 1);
            noisy     = ($urandom_range(99) < 15);
            repeat (run_len) begin
               if (noisy || $urandom_range(99) < 10) begin
                  label = LABEL_W'($urandom_range(LABEL_TOP));
               end else begin
                  label = run_class;
               end
               send_label(label);
               if (label < NUM_CLASSES) sent++;
            end
         end
      end

      drain();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
